// ===== hw/rtl/zis_pkg.sv =====
// Shared types and constants for the zone irrigation sequencer.
// No dependencies; imported by the sequencer top level, its checker and the testbench.
`default_nettype none

package zis_pkg;

   // Elapsed-time counter width and its saturation value
   localparam int unsigned TICK_W     = 24;
   localparam logic [23:0] TICKS_MAX  = 24'hFF_FFFF;
   // Ticks per second, and the fixed extra run time of every job
   localparam int unsigned SEC_TICKS   = 1000;
   localparam int unsigned START_TICKS = 200;
   // Gap length in ticks: up to 255 s * 1000
   localparam int unsigned GAP_W = 18;

   // Register file: byte address width, word index and register codes
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        REG_DELAY_SECONDS = 1'b0;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_ENQUEUE = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_START   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_WATER = 2'd1,
      PHASE_GAP   = 2'd2
   } phase_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [3:0]  zone_id;
      logic [7:0]  job_minutes;
      logic [5:0]  job_seconds;
      logic        use_nutrient;
      logic        run_kind;
   } req_type;

   typedef struct packed {
      logic        main_pump;
      logic        water_pump;
      logic        nutrient_pump;
      logic [3:0]  zone_valves;
      phase_type   phase;
      logic [3:0]  current_zone;
      logic        run_busy;
      logic        run_done;
      logic        finished_kind;
      logic        enqueue_dropped;
   } rsp_type;

   // One queued job as held in the job RAM
   typedef struct packed {
      logic        use_nutrient;
      logic [5:0]  job_seconds;
      logic [7:0]  job_minutes;
      logic [3:0]  zone_id;
   } job_type;

endpackage

`default_nettype wire

// ===== hw/rtl/zis_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module zis_ram #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/zone_irrigation_sequencer.sv =====
// Zone irrigation sequencer top level: job queue, run control, pump outputs.
// Depends on zis_pkg and zis_ram.
//
// Usage
//  - req channel: one command word per handshake (tick of 1 ms, enqueue
//    job, clear queue, start run). Accepted when req_valid is high and
//    req_stall low.
//  - rsp channel: exactly one result word per accepted command, in order,
//    giving pump, valve and run status after that command.
//  - APB port: delay_seconds at byte address 0; pready is always high.
//    Write only while the block is idle.
//  - Result word: registered in the output register, or in the skid
//    register while the receiver stalls. Throughput: one command per cycle,
//    sustained while req_stall is low; the only loop is the job RAM read,
//    which is prefetched at the next head pointer so a dequeue never waits.
//  - Receiver stall: an output register plus a one-word skid register;
//    req_stall rises only once the skid register is occupied.
//  - Reset (synchronous): run stopped, queue empty, outputs empty. The job
//    RAM is not cleared; only queued entries are ever read, so no clearing
//    pass is needed and the block takes commands straight after reset.
`default_nettype none

module zone_irrigation_sequencer #(
   parameter int QUEUE_DEPTH             = 16,
   parameter int TICKS_PER_MINUTE_FACTOR = 60
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // command channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire zis_pkg::req_type                    req_data,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output zis_pkg::rsp_type                         rsp_data,
   // register port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [zis_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [zis_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic      [zis_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                     pready
);

   import zis_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int JOB_W = $bits(job_type);
   localparam int unsigned MIN_TICKS = SEC_TICKS * TICKS_PER_MINUTE_FACTOR;

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   logic [7:0]        delay_ff;
   logic [GAP_W-1:0]  gap_ticks_ff, gap_ticks_in;

   logic              run_active_ff, run_active_in;
   logic              kind_ff, kind_in;
   logic              watering_ff, watering_in;
   logic              in_gap_ff, in_gap_in;
   job_type           job_ff, job_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic [TICK_W-1:0] limit_ff, limit_in;       // job run time in ticks
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // RAM write forwarding to the prefetched head entry
   logic              fwd_valid_ff, fwd_valid_in;
   job_type           fwd_data_ff;

   // output register and skid register
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   logic              skid_valid_ff, skid_valid_in;
   rsp_type           skid_ff, skid_in;

   // ---------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------
   logic accept;
   logic take;
   logic cfg_write;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // ---------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready
                      && (paddr[2] == REG_DELAY_SECONDS);
   assign prdata    = (paddr[2] == REG_DELAY_SECONDS)
                      ? {{(CSR_DATA_W-8){1'b0}}, delay_ff} : '0;
   // Gap length kept pre-scaled to ticks
   assign gap_ticks_in = GAP_W'(pwdata[7:0]) * GAP_W'(SEC_TICKS);

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= '0;
         gap_ticks_ff <= '0;
      end else if (cfg_write) begin
         delay_ff     <= pwdata[7:0];
         gap_ticks_ff <= gap_ticks_in;
      end
   end

   // ---------------------------------------------------------------
   // Job RAM: written at the tail, read continuously at the next head so
   // the head job is ready in the cycle a tick dequeues it.
   // ---------------------------------------------------------------
   logic     ram_wr_en;
   job_type  ram_wr_data;
   logic [JOB_W-1:0] ram_rd_data;
   job_type  head_job;

   assign ram_wr_data = '{use_nutrient: req_data.use_nutrient,
                          job_seconds:  req_data.job_seconds,
                          job_minutes:  req_data.job_minutes,
                          zone_id:      req_data.zone_id};

   zis_ram #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (ram_wr_data),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   // an enqueue landing on the entry being prefetched bypasses the RAM
   assign fwd_valid_in = ram_wr_en && (tail_ff == head_in);
   assign head_job     = fwd_valid_ff ? fwd_data_ff : job_type'(ram_rd_data);

   // ---------------------------------------------------------------
   // Command processing
   // ---------------------------------------------------------------
   logic             run_done;
   logic             finished_kind;
   logic             dropped;
   logic [PTR_W-1:0] head_inc;
   logic [PTR_W-1:0] tail_inc;
   logic             fifo_full;
   logic             fifo_empty;
   logic [TICK_W-1:0] head_limit;

   assign head_inc   = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_inc   = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign fifo_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign fifo_empty = (count_ff == '0);

   // minutes * ticks-per-minute + 200 + seconds * 1000
   assign head_limit = TICK_W'(head_job.job_minutes) * TICK_W'(MIN_TICKS)
                     + TICK_W'(START_TICKS)
                     + TICK_W'(head_job.job_seconds) * TICK_W'(SEC_TICKS);

   always_comb begin
      run_active_in = run_active_ff;
      kind_in       = kind_ff;
      watering_in   = watering_ff;
      in_gap_in     = in_gap_ff;
      job_in        = job_ff;
      ticks_in      = ticks_ff;
      limit_in      = limit_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      ram_wr_en     = 1'b0;
      run_done      = 1'b0;
      finished_kind = 1'b0;
      dropped       = 1'b0;

      if (accept) begin
         unique case (req_data.cmd)
            CMD_TICK: begin
               if (run_active_ff) begin
                  if (!watering_ff) begin
                     if (fifo_empty) begin
                        // queue ran dry between jobs: end of run
                        run_active_in = 1'b0;
                        run_done      = 1'b1;
                        finished_kind = kind_ff;
                     end else begin
                        job_in      = head_job;
                        limit_in    = head_limit;
                        head_in     = head_inc;
                        count_in    = count_ff - 1'b1;
                        watering_in = 1'b1;
                        ticks_in    = '0;
                     end
                  end else begin
                     if (ticks_ff != TICKS_MAX) begin
                        ticks_in = ticks_ff + 1'b1;
                     end
                     // ticks+1 > limit, written on the old count
                     if (!in_gap_ff && (ticks_ff >= limit_ff)) begin
                        if (!fifo_empty) begin
                           in_gap_in = 1'b1;
                           ticks_in  = '0;
                        end else begin
                           watering_in = 1'b0;
                        end
                     end
                     if (in_gap_ff && (ticks_ff >= TICK_W'(gap_ticks_ff))) begin
                        in_gap_in   = 1'b0;
                        watering_in = 1'b0;
                     end
                  end
               end
            end
            CMD_ENQUEUE: begin
               if (fifo_full) begin
                  dropped = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
                  tail_in   = tail_inc;
                  count_in  = count_ff + 1'b1;
               end
            end
            CMD_CLEAR: begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end
            CMD_START: begin
               if (!run_active_ff) begin
                  run_active_in = 1'b1;
                  kind_in       = req_data.run_kind;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result word built from the updated state
   rsp_type result;
   logic    pumps_on;

   always_comb begin
      pumps_on = watering_in && !in_gap_in;
      result.main_pump     = pumps_on;
      result.water_pump    = pumps_on && !job_in.use_nutrient;
      result.nutrient_pump = pumps_on && job_in.use_nutrient;
      // valves only for zones 1 to 4
      if (pumps_on && (job_in.zone_id != 4'd0) && (job_in.zone_id <= 4'd4)) begin
         result.zone_valves = 4'b0001 << job_in.zone_id[1:0] - 2'd1;
      end else begin
         result.zone_valves = 4'b0000;
      end
      if (in_gap_in) begin
         result.phase = PHASE_GAP;
      end else if (watering_in) begin
         result.phase = PHASE_WATER;
      end else begin
         result.phase = PHASE_IDLE;
      end
      result.current_zone    = job_in.zone_id;
      result.run_busy        = run_active_in;
      result.run_done        = run_done;
      result.finished_kind   = finished_kind;
      result.enqueue_dropped = dropped;
   end

   // ---------------------------------------------------------------
   // Output register and skid
   // ---------------------------------------------------------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_in       = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   // ---------------------------------------------------------------
   // State update
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         kind_ff       <= 1'b0;
         watering_ff   <= 1'b0;
         in_gap_ff     <= 1'b0;
         job_ff        <= '0;
         ticks_ff      <= '0;
         limit_ff      <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         fwd_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         run_active_ff <= run_active_in;
         kind_ff       <= kind_in;
         watering_ff   <= watering_in;
         in_gap_ff     <= in_gap_in;
         job_ff        <= job_in;
         ticks_ff      <= ticks_in;
         limit_ff      <= limit_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         fwd_valid_ff  <= fwd_valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= ram_wr_data;
      out_ff      <= out_in;
      skid_ff     <= skid_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/zis_checker.sv =====
// Port-level checks for the zone irrigation sequencer, bound to its top level.
// Depends on zis_pkg and zone_irrigation_sequencer.
`default_nettype none

module zis_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire zis_pkg::rsp_type rsp_data
);

   import zis_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed under stall");

   // nothing left in the output stages after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // pumps run only while watering inside an active run, with exactly one of water and nutrient pump on
   a_pumps_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.main_pump |->
         rsp_data.phase == PHASE_WATER && rsp_data.run_busy
         && (rsp_data.water_pump != rsp_data.nutrient_pump))
      else $error("pump drive outside a watering phase");

   // a finished run leaves everything switched off
   a_done_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.run_done |->
         !rsp_data.run_busy && rsp_data.phase == PHASE_IDLE
         && rsp_data.zone_valves == 4'b0000 && !rsp_data.main_pump)
      else $error("outputs still active at end of run");

   // at most one valve, and only with the main pump on
   a_valves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_data.zone_valves)
         && (rsp_data.zone_valves == 4'b0000 || rsp_data.main_pump))
      else $error("bad valve drive");

endmodule

bind zone_irrigation_sequencer zis_checker u_zis_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== sim/tb_zone_irrigation_sequencer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the zone irrigation sequencer: random command words,
// per-word status prediction and an APB check of delay_seconds.
// Depends on zis_pkg and zone_irrigation_sequencer only.

module tb_zone_irrigation_sequencer;

   import zis_pkg::*;

   localparam int QUEUE_DEPTH             = 16;
   localparam int TICKS_PER_MINUTE_FACTOR = 60;
   localparam int CYCLE_LIMIT             = 500000;  // far above the slowest correct run
   localparam int HOLD_CYCLES             = 60;      // receiver back-pressure burst
   localparam int REQ_W                   = $bits(req_type);

   // Tracks the sequencer's run, job queue and timers and holds the status words
   // still owed by the block, oldest first.
   class status_tracker #(int DEPTH = 16, int MIN_FACTOR = 60);
      bit [7:0]    gap_seconds;
      bit          running, run_kind_now, watering, in_gap;
      job_type     job_now;
      int unsigned ticks;
      job_type     slots [DEPTH];
      int          head, tail, count;
      rsp_type     status_due [$];
      int          errors, checked, runs_ended, refusals;

      function new();
         job_now = '0;
      endfunction

      // ticks a job runs before its outputs switch off
      function int unsigned job_span(job_type j);
         return int'(j.job_minutes) * SEC_TICKS * MIN_FACTOR + START_TICKS
              + int'(j.job_seconds) * SEC_TICKS;
      endfunction

      function void advance_tick(output bit done, output bit kind);
         done = 1'b0;
         kind = 1'b0;
         if (!running) return;
         if (watering && ticks < TICKS_MAX) ticks++;
         if (!watering && count == 0) begin
            running = 1'b0;
            done    = 1'b1;
            kind    = run_kind_now;
            return;
         end
         if (!watering) begin
            job_now  = slots[head];
            head     = (head + 1) % DEPTH;
            count--;
            watering = 1'b1;
            ticks    = 0;
         end
         if (watering && !in_gap && ticks > job_span(job_now)) begin
            if (count != 0) begin
               in_gap = 1'b1;
               ticks  = 0;
            end else
               watering = 1'b0;
         end
         if (in_gap && ticks > int'(gap_seconds) * SEC_TICKS) begin
            in_gap   = 1'b0;
            watering = 1'b0;
         end
      endfunction

      // accepted command word: update state, queue the status word it yields
      function void note_command(req_type w);
         rsp_type want;
         job_type j;
         bit      done, kind, refused, on;
         done    = 1'b0;
         kind    = 1'b0;
         refused = 1'b0;
         case (w.cmd)
            CMD_TICK: advance_tick(done, kind);
            CMD_ENQUEUE: begin
               if (count >= DEPTH)
                  refused = 1'b1;
               else begin
                  j.zone_id      = w.zone_id;
                  j.job_minutes  = w.job_minutes;
                  j.job_seconds  = w.job_seconds;
                  j.use_nutrient = w.use_nutrient;
                  slots[tail]    = j;
                  tail           = (tail + 1) % DEPTH;
                  count++;
               end
            end
            CMD_CLEAR: begin
               head  = 0;
               tail  = 0;
               count = 0;
            end
            CMD_START: begin
               if (!running) begin
                  running      = 1'b1;
                  run_kind_now = w.run_kind;
               end
            end
         endcase
         on                   = watering && !in_gap;
         want.main_pump       = on;
         want.water_pump      = on && !job_now.use_nutrient;
         want.nutrient_pump   = on && job_now.use_nutrient;
         want.zone_valves     = (on && job_now.zone_id >= 1 && job_now.zone_id <= 4)
                              ? 4'(1 << (job_now.zone_id - 1)) : 4'b0;
         want.phase           = in_gap ? PHASE_GAP : (watering ? PHASE_WATER : PHASE_IDLE);
         want.current_zone    = job_now.zone_id;
         want.run_busy        = running;
         want.run_done        = done;
         want.finished_kind   = kind;
         want.enqueue_dropped = refused;
         if (done) runs_ended++;
         if (refused) refusals++;
         status_due.insert(status_due.size(), want);
      endfunction

      function void field_check(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_status(rsp_type got);
         rsp_type want;
         if (status_due.size() == 0) begin
            $display("%0t: status word with nothing expected, actual %h", $time, got);
            errors++;
            return;
         end
         want = status_due.pop_front();
         checked++;
         field_check("main_pump", want.main_pump, got.main_pump);
         field_check("water_pump", want.water_pump, got.water_pump);
         field_check("nutrient_pump", want.nutrient_pump, got.nutrient_pump);
         field_check("zone_valves", want.zone_valves, got.zone_valves);
         field_check("phase", want.phase, got.phase);
         field_check("current_zone", want.current_zone, got.current_zone);
         field_check("run_busy", want.run_busy, got.run_busy);
         field_check("run_done", want.run_done, got.run_done);
         field_check("finished_kind", want.finished_kind, got.finished_kind);
         field_check("enqueue_dropped", want.enqueue_dropped, got.enqueue_dropped);
      endfunction
   endclass

   typedef status_tracker #(QUEUE_DEPTH, TICKS_PER_MINUTE_FACTOR) tracker_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   tracker_type board = new();

   bit steady       = 1'b0;  // both sides go flat out while set
   bit hold_request = 1'b0;  // asks the receiver for a long stall
   int hold_left    = 0;
   int items_sent   = 0;
   int cycles       = 0;

   zone_irrigation_sequencer #(
      .QUEUE_DEPTH            (QUEUE_DEPTH),
      .TICKS_PER_MINUTE_FACTOR(TICKS_PER_MINUTE_FACTOR)
   ) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver. Values read here are the ones from before the edge, so the
   // handshake is taken exactly as the block sees it. The long hold is
   // counted down in this process alone.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_status(rsp_data);
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= !steady && ($urandom_range(99) < 24);
   end

   // Offer one command word, with random idle cycles ahead of it, and hold it
   // until the block takes it. Prediction happens at the accepting edge.
   task automatic send_word(input req_type w);
      while (!steady && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      board.note_command(w);
      items_sent++;
   endtask

   // Sender pause: nothing offered until every status word is back.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (board.status_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Setup then access phase; returns with the bus idle so that back-to-back
   // accesses never drive psel twice in one step.
   task automatic csr_access(input bit write_it, input logic [7:0] value,
                             output logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_it;
      paddr   <= CSR_ADDR_W'(REG_DELAY_SECONDS) << 2;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic verify_delay();
      logic [CSR_DATA_W-1:0] seen;
      csr_access(1'b0, 8'd0, seen);
      if (seen !== CSR_DATA_W'(board.gap_seconds)) begin
         $display("%0t: delay_seconds expected %0d, actual %0d", $time,
                  board.gap_seconds, seen);
         board.errors++;
      end
   endtask

   task automatic program_delay(input logic [7:0] value);
      logic [CSR_DATA_W-1:0] unused;
      wait_quiet();
      csr_access(1'b1, value, unused);
      board.gap_seconds = value;
      verify_delay();
   endtask

   function automatic req_type any_word(cmd_type c);
      logic [REQ_W-1:0] raw;
      req_type w;
      raw   = REQ_W'($urandom);
      w     = raw;
      w.cmd = c;
      return w;
   endfunction

   // Jobs that actually get watered stay short: 201 ticks, now and then 1201.
   function automatic req_type short_job();
      req_type w;
      w             = any_word(CMD_ENQUEUE);
      w.job_minutes = 8'd0;
      w.job_seconds = ($urandom_range(9) == 0) ? 6'd1 : 6'd0;
      return w;
   endfunction

   // Well-formed runs (enqueue, start, tick to the end) with noise mixed in:
   // stray enqueues, starts while running, and clears that cut a run short.
   task automatic random_runs(input int target);
      int stop_at;
      int pick;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         if ($urandom_range(3) == 0) send_word(any_word(CMD_CLEAR));
         repeat ($urandom_range(1, 2)) send_word(short_job());
         repeat ($urandom_range(0, 3)) send_word(any_word(CMD_TICK));
         send_word(any_word(CMD_START));
         while (board.running) begin
            pick = $urandom_range(99);
            if (pick < 97)
               send_word(any_word(CMD_TICK));
            else if (pick < 98)
               send_word(board.count == QUEUE_DEPTH ? any_word(CMD_ENQUEUE) : short_job());
            else if (pick < 99)
               send_word(any_word(CMD_START));
            else
               send_word(any_word(CMD_CLEAR));
         end
         if ($urandom_range(2) == 0) wait_quiet();
      end
   endtask

   initial begin
      req_type w;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      verify_delay();

      // --- directed words ---
      send_word(any_word(CMD_TICK));            // no run: nothing moves
      w          = any_word(CMD_START);
      w.run_kind = 1'b1;
      send_word(w);                             // start on an empty queue
      send_word(any_word(CMD_TICK));            // run ends at once, done pulses
      w              = any_word(CMD_ENQUEUE);   // all fields at their top,
      w.zone_id      = '1;                      // seconds past 59 included
      w.job_minutes  = '1;
      w.job_seconds  = '1;
      w.use_nutrient = 1'b1;
      w.run_kind     = 1'b1;
      send_word(w);
      w     = '0;
      w.cmd = CMD_ENQUEUE;
      send_word(w);
      send_word(any_word(CMD_CLEAR));           // neither job may ever run
      repeat (QUEUE_DEPTH) send_word(any_word(CMD_ENQUEUE));
      w     = '1;
      w.cmd = CMD_ENQUEUE;
      send_word(w);                             // queue full: refused
      send_word(any_word(CMD_CLEAR));

      // --- random runs, first stretch with no idling on either side ---
      steady = 1'b1;
      random_runs(200);
      steady = 1'b0;
      random_runs(200);

      // Longest gap: run into it, let it age, then shorten the gap live so
      // the run finishes without waiting out 255 s.
      program_delay(8'd255);
      repeat (2) send_word(short_job());
      send_word(any_word(CMD_START));
      while (!board.in_gap) send_word(any_word(CMD_TICK));
      repeat (50) send_word(any_word(CMD_TICK));
      program_delay(8'd0);
      while (board.running) send_word(any_word(CMD_TICK));

      // Receiver holds off while the sender keeps offering: input stalls.
      steady       = 1'b1;
      hold_request = 1'b1;
      repeat (40) send_word(any_word(CMD_TICK));
      steady       = 1'b0;

      random_runs(200);

      wait_quiet();
      repeat (4) @(posedge clock);
      if (board.status_due.size() != 0) begin
         $display("%0t: %0d status words never arrived", $time, board.status_due.size());
         board.errors++;
      end
      $display("Covered %0d command words, %0d status words checked, %0d runs ended,",
               items_sent, board.checked, board.runs_ended);
      $display("%0d enqueues refused; gap settings of 0 and 255 s", board.refusals);
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
